@@ hw/rtl/assert_macros.svh @@
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

@@ hw/rtl/mrte_pkg.sv @@
`timescale 1ns / 1ps
package mrte_pkg;
    localparam logic [4:0] OP_AND = 5'd0, OP_OR = 5'd1, OP_NOR = 5'd2, OP_XOR = 5'd3;
    localparam logic [4:0] OP_SLLV = 5'd4, OP_SLL = 5'd5, OP_SRAV = 5'd6, OP_SRA = 5'd7;
    localparam logic [4:0] OP_SRLV = 5'd8, OP_SRL = 5'd9, OP_MFHI = 5'd10, OP_MFLO = 5'd11;
    localparam logic [4:0] OP_MTHI = 5'd12, OP_MTLO = 5'd13, OP_ADD = 5'd14, OP_ADDU = 5'd15;
    localparam logic [4:0] OP_SUB = 5'd16, OP_SUBU = 5'd17, OP_SLT = 5'd18, OP_SLTU = 5'd19;
    localparam logic [4:0] OP_MULT = 5'd20, OP_MULTU = 5'd21, OP_DIV = 5'd22;
    localparam logic [4:0] OP_DIVU = 5'd23, OP_JALR = 5'd24, OP_JR = 5'd25;
    localparam logic [4:0] OP_BREAK = 5'd26, OP_MFC0 = 5'd27, OP_MTC0 = 5'd28;
    localparam logic [4:0] OP_ERET = 5'd29, OP_SYSCALL = 5'd30;

    localparam logic [4:0] CP0_STATUS = 5'd12, CP0_CAUSE = 5'd13, CP0_EPC = 5'd14;
    localparam logic [4:0] EXC_SYSCALL = 5'h08, EXC_BREAK = 5'h09, EXC_OVERFLOW = 5'h0C;
    localparam logic [1:0] RK_NONE = 2'd0, RK_JUMP = 2'd1, RK_ERET = 2'd2;

    // divider control and status
    typedef struct packed {
        logic        start;
        logic        sgn;
        logic [31:0] a;
        logic [31:0] b;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [31:0] rem;
    } div_rsp_t;
endpackage

@@ hw/rtl/mips_r_type_execute_unit.sv @@
`timescale 1ns / 1ps
// Channel | Dir | Contents
// s_axis  | in  | mode, src_a, src_b, shift_amount, instr_pc, in_delay_slot, cp0_index
// m_axis  | out | write_enable, write_value, redirect_kind, redirect_target,
//         |     | raise_exception, exc_code, halt
// One beat in, one beat out. Most ops register their result directly; div/divu
// use the one-bit-per-cycle shared divider. mult/multu go through a
// registered 33x33 multiplier. s_axis_tready is low while an op is in flight
// or its result is held. rst_n clears HI, LO and CP0 at once (CP0 valid
// bits; no clearing pass).
module mips_r_type_execute_unit
    import mrte_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [4:0] mode, [36:5] src_a, [68:37] src_b, [73:69] shift_amount,
    // [105:74] instr_pc, [106] in_delay_slot, [111:107] cp0_index
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] write_enable, [32:1] write_value, [34:33] redirect_kind,
    // [66:35] redirect_target, [67] raise_exception, [72:68] exc_code, [73] halt
    output logic [79:0]  m_axis_tdata
);
`include "assert_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0, ST_MUL = 2'd1, ST_DIV = 2'd2, ST_OUT = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [4:0]  op_reg;
    logic [31:0] a_reg, b_reg, pc_reg;
    logic [4:0]  sa_reg, ci_reg;
    logic        slot_reg, go_reg;
    logic [31:0] hi_reg, lo_reg;
    logic [31:0] cp0_mem [32];
    logic [31:0] cp0_vld_reg;
    logic [79:0] out_reg;
    logic signed [65:0] prod_reg;
    logic        mul_wait_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    mrte_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    function automatic logic [31:0] cp0_rd(input logic [4:0] idx, input logic [31:0] vld,
                                           input logic [31:0] v);
        cp0_rd = vld[idx] ? v : 32'd0;
    endfunction

    logic [31:0] status_v, cause_v, epc_v, cpx_v;
    assign status_v = cp0_rd(CP0_STATUS, cp0_vld_reg, cp0_mem[CP0_STATUS]);
    assign cause_v  = cp0_rd(CP0_CAUSE, cp0_vld_reg, cp0_mem[CP0_CAUSE]);
    assign epc_v    = cp0_rd(CP0_EPC, cp0_vld_reg, cp0_mem[CP0_EPC]);
    assign cpx_v    = cp0_rd(ci_reg, cp0_vld_reg, cp0_mem[ci_reg]);

    assign s_axis_tready = (state_reg == ST_IDLE) && !go_reg;
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = out_reg;

    // combinational datapath
    logic [31:0] sum, dif, wv, rt, sres;
    logic        we, ex, halt, ovf, sgn_in;
    logic [1:0]  rk;
    logic [4:0]  code, shamt;
    logic [63:0] sra_ext;

    always_comb
    begin
        sum = a_reg + b_reg;
        dif = a_reg - b_reg;
        shamt = (op_reg == OP_SLL || op_reg == OP_SRA || op_reg == OP_SRL) ? sa_reg : a_reg[4:0];
        sgn_in = b_reg[31];
        sra_ext = {{32{sgn_in}}, b_reg} >> shamt;
        sres = 32'd0;
        we = 1'b0; wv = 32'd0; rk = RK_NONE; rt = 32'd0;
        ex = 1'b0; code = 5'd0; halt = 1'b0; ovf = 1'b0;
        case (op_reg)
            OP_AND: begin we = 1'b1; wv = a_reg & b_reg; end
            OP_OR: begin we = 1'b1; wv = a_reg | b_reg; end
            OP_NOR: begin we = 1'b1; wv = ~(a_reg | b_reg); end
            OP_XOR: begin we = 1'b1; wv = a_reg ^ b_reg; end
            OP_SLLV, OP_SLL: begin we = 1'b1; wv = b_reg << shamt; end
            OP_SRAV, OP_SRA: begin we = 1'b1; wv = sra_ext[31:0]; end
            OP_SRLV, OP_SRL: begin we = 1'b1; wv = b_reg >> shamt; end
            OP_MFHI: begin we = 1'b1; wv = hi_reg; end
            OP_MFLO: begin we = 1'b1; wv = lo_reg; end
            OP_ADD:
            begin
                ovf = (sum[31] ^ a_reg[31]) & ~(a_reg[31] ^ b_reg[31]);
                if (ovf) begin ex = 1'b1; code = EXC_OVERFLOW; end
                else begin we = 1'b1; wv = sum; end
            end
            OP_ADDU: begin we = 1'b1; wv = sum; end
            OP_SUB:
            begin
                ovf = (dif[31] ^ a_reg[31]) & (a_reg[31] ^ b_reg[31]);
                if (ovf) begin ex = 1'b1; code = EXC_OVERFLOW; end
                else begin we = 1'b1; wv = dif; end
            end
            OP_SUBU: begin we = 1'b1; wv = dif; end
            OP_SLT:
            begin
                we = 1'b1;
                wv = {31'd0, ({~a_reg[31], a_reg[30:0]} < {~b_reg[31], b_reg[30:0]})};
            end
            OP_SLTU: begin we = 1'b1; wv = {31'd0, (a_reg < b_reg)}; end
            OP_JALR: begin we = 1'b1; wv = pc_reg + 32'd8; rk = RK_JUMP; rt = a_reg; end
            OP_JR: begin rk = RK_JUMP; rt = a_reg; end
            OP_BREAK: begin ex = 1'b1; code = EXC_BREAK; halt = 1'b1; end
            OP_MFC0: begin we = 1'b1; wv = cpx_v; end
            OP_ERET: begin rk = RK_ERET; rt = epc_v; end
            OP_SYSCALL: begin ex = 1'b1; code = EXC_SYSCALL; end
            default: sres = 32'd0;
        endcase
        wv = wv | sres;
    end

    assign dreq.start = go_reg && (op_reg == OP_DIV || op_reg == OP_DIVU);
    assign dreq.sgn   = (op_reg == OP_DIV);
    assign dreq.a     = a_reg;
    assign dreq.b     = b_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (go_reg)
                begin
                    if (op_reg == OP_DIV || op_reg == OP_DIVU) state_next = ST_DIV;
                    else if (op_reg == OP_MULT || op_reg == OP_MULTU) state_next = ST_MUL;
                    else state_next = ST_OUT;
                end
            ST_MUL: if (!mul_wait_reg) state_next = ST_OUT;
            ST_DIV: if (drsp.done) state_next = ST_OUT;
            ST_OUT: if (m_axis_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            go_reg       <= 1'b0;
            mul_wait_reg <= 1'b0;
            hi_reg       <= 32'd0;
            lo_reg       <= 32'd0;
            cp0_vld_reg  <= 32'd0;
        end
        else
        begin
            state_reg    <= state_next;
            go_reg       <= s_axis_tvalid && s_axis_tready;
            mul_wait_reg <= go_reg && (op_reg == OP_MULT || op_reg == OP_MULTU);
            if (go_reg)
            begin
                if (op_reg == OP_MTHI) hi_reg <= a_reg;
                if (op_reg == OP_MTLO) lo_reg <= a_reg;
                if (op_reg == OP_MTC0) cp0_vld_reg[ci_reg] <= 1'b1;
                if (ex)
                begin
                    cp0_vld_reg[CP0_STATUS] <= 1'b1;
                    cp0_vld_reg[CP0_CAUSE]  <= 1'b1;
                    cp0_vld_reg[CP0_EPC]    <= 1'b1;
                end
                if (op_reg == OP_ERET) cp0_vld_reg[CP0_STATUS] <= 1'b1;
            end
            if (state_reg == ST_MUL && !mul_wait_reg)
            begin
                hi_reg <= prod_reg[63:32];
                lo_reg <= prod_reg[31:0];
            end
            if (state_reg == ST_DIV && drsp.done)
            begin
                hi_reg <= drsp.rem;
                lo_reg <= drsp.quo;
            end
        end
    end

    // input capture, product, result and CP0 writes
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg   <= s_axis_tdata[4:0];
            a_reg    <= s_axis_tdata[36:5];
            b_reg    <= s_axis_tdata[68:37];
            sa_reg   <= s_axis_tdata[73:69];
            pc_reg   <= s_axis_tdata[105:74];
            slot_reg <= s_axis_tdata[106];
            ci_reg   <= s_axis_tdata[111:107];
        end
        if (go_reg)
        begin
            prod_reg <= $signed({(op_reg == OP_MULT) & a_reg[31], a_reg}) *
                        $signed({(op_reg == OP_MULT) & b_reg[31], b_reg});
            out_reg <= {6'd0, halt, code, ex, rt, rk, wv, we};
            if (op_reg == OP_MTC0) cp0_mem[ci_reg] <= b_reg;
            if (ex)
            begin
                cp0_mem[CP0_CAUSE] <= {slot_reg, cause_v[30:8], 1'b0, code, cause_v[1:0]};
                cp0_mem[CP0_EPC] <= slot_reg ? (pc_reg - 32'd4) : pc_reg;
                cp0_mem[CP0_STATUS] <= status_v | 32'h2;
            end
            if (op_reg == OP_ERET) cp0_mem[CP0_STATUS] <= status_v & 32'hfffffffd;
        end
    end

    `ASSERT_IMPL(a_no_accept_busy, (state_reg != ST_IDLE) |-> !s_axis_tready,
        "accepting while busy")
    `ASSERT_IMPL(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid,
        "result dropped under stall")
    `ASSERT_NEVER(a_we_and_exc, m_axis_tvalid && out_reg[0] && out_reg[67],
        "write and exception together")
endmodule

@@ hw/rtl/mrte_divider.sv @@
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle, sign fix at end.
module mrte_divider
    import mrte_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
`include "assert_macros.svh"

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] q_reg, r_reg, d_reg, a_reg;
    logic        na_reg, nq_reg, zero_reg, done_reg;

    logic [33:0] trial;
    logic [32:0] r_sh;
    logic [31:0] ma, mb;
    logic        na, nb;

    assign na = req.sgn & req.a[31];
    assign nb = req.sgn & req.b[31];
    assign ma = na ? (32'd0 - req.a) : req.a;
    assign mb = nb ? (32'd0 - req.b) : req.b;
    // partial remainder keeps its top bit when shifted (divisor may exceed 2^31)
    assign r_sh  = {r_reg, q_reg[31]};
    assign trial = {1'b0, r_sh} - {2'b00, d_reg};

    // iteration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg    <= ma;
            r_reg    <= 32'd0;
            d_reg    <= mb;
            a_reg    <= req.a;
            na_reg   <= na;
            nq_reg   <= na ^ nb;
            zero_reg <= (req.b == 32'd0);
        end
        else if (busy_reg)
        begin
            if (!trial[33])
            begin
                r_reg <= trial[31:0];
                q_reg <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                r_reg <= r_sh[31:0];
                q_reg <= {q_reg[30:0], 1'b0};
            end
        end
    end

    // result with sign and divide-by-zero fixups
    always_comb
    begin
        rsp.done = done_reg;
        if (zero_reg)
        begin
            rsp.quo = 32'hffffffff;
            rsp.rem = a_reg;
        end
        else
        begin
            rsp.quo = nq_reg ? (32'd0 - q_reg) : q_reg;
            rsp.rem = na_reg ? (32'd0 - r_reg) : r_reg;
        end
    end

    `ASSERT_NEVER(a_start_busy, req.start && busy_reg, "divider started while busy")
    `ASSERT_IMPL(a_done_once, done_reg |=> !done_reg, "divider done held two cycles")
    `ASSERT_IMPL(a_cnt_range, busy_reg |-> cnt_reg < 6'd32, "divider count overrun")
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import mrte_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [4:0]  cp0_index;
        logic        in_delay_slot;
        logic [31:0] instr_pc;
        logic [4:0]  shift_amount;
        logic [31:0] src_b;
        logic [31:0] src_a;
        logic [4:0]  mode;
    } op_beat_t;

    typedef struct packed {
        logic        halt;
        logic [4:0]  exc_code;
        logic        raise_exception;
        logic [31:0] redirect_target;
        logic [1:0]  redirect_kind;
        logic [31:0] write_value;
        logic        write_enable;
    } res_beat_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [79:0]  m_axis_tdata;

    mips_r_type_execute_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // predicted architectural state
    logic [31:0] hi_model;
    logic [31:0] lo_model;
    logic [31:0] cp0_model [32];

    op_beat_t  op_queue [$];
    res_beat_t result_queue [$];
    int        error_count;
    int        ops_sent;
    int        results_seen;
    int        exc_seen;
    bit        stim_done;
    int        idle_cycles;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got, want);
    endtask

    function automatic void enter_exception(input logic [4:0] code, input logic [31:0] pc,
                                            input logic slot);
        logic [31:0] cause;
        cause = (cp0_model[CP0_CAUSE] & 32'hffffff03) | {25'd0, code, 2'b00};
        cause[31] = slot;
        cp0_model[CP0_CAUSE] = cause;
        cp0_model[CP0_EPC] = slot ? pc - 32'd4 : pc;
        cp0_model[CP0_STATUS][1] = 1'b1;
    endfunction

    function automatic void divide_model(input logic [31:0] a, input logic [31:0] b,
                                         input logic sgn);
        logic        na;
        logic        nb;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] r;
        if (b == 32'd0)
        begin
            hi_model = a;
            lo_model = 32'hffffffff;
            return;
        end
        na = sgn & a[31];
        nb = sgn & b[31];
        ma = na ? -a : a;
        mb = nb ? -b : b;
        q = ma / mb;
        r = ma % mb;
        lo_model = (na != nb) ? -q : q;
        hi_model = na ? -r : r;
    endfunction

    // execute one op against the state copy; returns the expected beat
    function automatic res_beat_t execute_op(input op_beat_t op);
        res_beat_t   res;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] t;
        logic [63:0] p;
        res = '0;
        a = op.src_a;
        b = op.src_b;
        case (op.mode)
            OP_AND:   begin res.write_enable = 1'b1; res.write_value = a & b; end
            OP_OR:    begin res.write_enable = 1'b1; res.write_value = a | b; end
            OP_NOR:   begin res.write_enable = 1'b1; res.write_value = ~(a | b); end
            OP_XOR:   begin res.write_enable = 1'b1; res.write_value = a ^ b; end
            OP_SLLV:  begin res.write_enable = 1'b1; res.write_value = b << a[4:0]; end
            OP_SLL:
            begin
                res.write_enable = 1'b1;
                res.write_value = b << op.shift_amount;
            end
            OP_SRAV:
            begin
                res.write_enable = 1'b1;
                res.write_value = $signed(b) >>> a[4:0];
            end
            OP_SRA:
            begin
                res.write_enable = 1'b1;
                res.write_value = $signed(b) >>> op.shift_amount;
            end
            OP_SRLV:  begin res.write_enable = 1'b1; res.write_value = b >> a[4:0]; end
            OP_SRL:
            begin
                res.write_enable = 1'b1;
                res.write_value = b >> op.shift_amount;
            end
            OP_MFHI:  begin res.write_enable = 1'b1; res.write_value = hi_model; end
            OP_MFLO:  begin res.write_enable = 1'b1; res.write_value = lo_model; end
            OP_MTHI:  hi_model = a;
            OP_MTLO:  lo_model = a;
            OP_ADD, OP_SUB:
            begin
                t = (op.mode == OP_ADD) ? a + b : a - b;
                if ((t[31] != a[31]) && ((op.mode == OP_ADD) == (a[31] == b[31])))
                begin
                    res.raise_exception = 1'b1;
                    res.exc_code = EXC_OVERFLOW;
                    enter_exception(EXC_OVERFLOW, op.instr_pc, op.in_delay_slot);
                end
                else
                begin
                    res.write_enable = 1'b1;
                    res.write_value = t;
                end
            end
            OP_ADDU:  begin res.write_enable = 1'b1; res.write_value = a + b; end
            OP_SUBU:  begin res.write_enable = 1'b1; res.write_value = a - b; end
            OP_SLT:
            begin
                res.write_enable = 1'b1;
                res.write_value = {31'd0, $signed(a) < $signed(b)};
            end
            OP_SLTU:  begin res.write_enable = 1'b1; res.write_value = {31'd0, a < b}; end
            OP_MULT:
            begin
                p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                {hi_model, lo_model} = p;
            end
            OP_MULTU:
            begin
                p = {32'd0, a} * {32'd0, b};
                {hi_model, lo_model} = p;
            end
            OP_DIV:   divide_model(a, b, 1'b1);
            OP_DIVU:  divide_model(a, b, 1'b0);
            OP_JALR:
            begin
                res.write_enable = 1'b1;
                res.write_value = op.instr_pc + 32'd8;
                res.redirect_kind = RK_JUMP;
                res.redirect_target = a;
            end
            OP_JR:    begin res.redirect_kind = RK_JUMP; res.redirect_target = a; end
            OP_BREAK:
            begin
                res.raise_exception = 1'b1;
                res.exc_code = EXC_BREAK;
                res.halt = 1'b1;
                enter_exception(EXC_BREAK, op.instr_pc, op.in_delay_slot);
            end
            OP_MFC0:
            begin
                res.write_enable = 1'b1;
                res.write_value = cp0_model[op.cp0_index];
            end
            OP_MTC0:  cp0_model[op.cp0_index] = b;
            OP_ERET:
            begin
                res.redirect_kind = RK_ERET;
                res.redirect_target = cp0_model[CP0_EPC];
                cp0_model[CP0_STATUS][1] = 1'b0;
            end
            OP_SYSCALL:
            begin
                res.raise_exception = 1'b1;
                res.exc_code = EXC_SYSCALL;
                enter_exception(EXC_SYSCALL, op.instr_pc, op.in_delay_slot);
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    function automatic op_beat_t make_op(input logic [4:0] mode, input logic [31:0] a,
                                         input logic [31:0] b);
        op_beat_t op;
        op.mode = mode;
        op.src_a = a;
        op.src_b = b;
        op.shift_amount = 5'($urandom_range(0, 31));
        op.instr_pc = $urandom;
        op.in_delay_slot = 1'($urandom_range(0, 1));
        op.cp0_index = 5'($urandom_range(0, 31));
        return op;
    endfunction

    // stimulus
    initial
    begin
        op_beat_t op;
        int       n;
        rst_n = 1'b0;
        stim_done = 1'b0;
        for (int i = 0; i < 32; i++)
            cp0_model[i] = '0;
        hi_model = '0;
        lo_model = '0;
        // directed: extremes, the special cases, then every third op code
        op_queue.push_back(make_op(OP_MFC0, 32'hffffffff, 32'hffffffff));
        op_queue.push_back(make_op(OP_ADD, 32'h7fffffff, 32'd1));
        op_queue.push_back(make_op(OP_SUB, 32'h80000000, 32'd1));
        op_queue.push_back(make_op(OP_DIV, 32'h80000000, 32'hffffffff));
        op_queue.push_back(make_op(OP_DIV, 32'hfffffff9, 32'd0));
        op_queue.push_back(make_op(OP_DIVU, 32'hfffffff9, 32'd2));
        op_queue.push_back(make_op(OP_DIV, 32'hfffffff9, 32'd2));
        op_queue.push_back(make_op(OP_DIVU, 32'hffffffff, 32'h80000001));
        op_queue.push_back(make_op(OP_MULT, 32'hffffffff, 32'h80000000));
        op_queue.push_back(make_op(OP_SRAV, 32'hffffffe1, 32'h80000000));
        op = make_op(OP_JALR, 32'hffffffff, 32'd0);
        op.instr_pc = 32'hfffffffc;
        op_queue.push_back(op);
        op = make_op(OP_SYSCALL, 32'd0, 32'd0);
        op.in_delay_slot = 1'b1;
        op.instr_pc = 32'd0;
        op_queue.push_back(op);
        op_queue.push_back(make_op(OP_ERET, 32'd0, 32'd0));
        op = make_op(OP_MTC0, 32'd0, 32'hffffffff);
        op.cp0_index = CP0_CAUSE;
        op_queue.push_back(op);
        op = make_op(OP_BREAK, 32'd0, 32'd0);
        op.in_delay_slot = 1'b0;
        op_queue.push_back(op);
        op_queue.push_back(make_op(5'd31, 32'hffffffff, 32'hffffffff));
        for (int m = 0; m <= 30; m += 3)
            op_queue.push_back(make_op(m[4:0], $urandom, $urandom));
        // random, divides kept to a minority to bound run time
        n = 0;
        while (n < 700)
        begin
            op = make_op(5'($urandom_range(0, 31)), rand_word(), rand_word());
            if ((op.mode == OP_DIV || op.mode == OP_DIVU) && $urandom_range(0, 2) != 0)
                op.mode = OP_MFHI;
            if (op.mode == OP_MFC0 || op.mode == OP_MTC0)
                if ($urandom_range(0, 1))
                    op.cp0_index = 5'($urandom_range(12, 14));
            op_queue.push_back(op);
            n++;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (op_queue.size() == 0);
        stim_done = 1'b1;
    end

    // input accept flag latched at the rising edge
    logic s_axis_tready_q;

    // driver: bursts with random gaps
    int burst_left;
    int gap_left;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else if (!s_axis_tvalid || s_axis_tready_q)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (op_queue.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= op_queue.pop_front();
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 20);
                end
                burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_axis_tready_q <= 1'b0;
        else
        begin
            s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                result_queue.push_back(execute_op(op_beat_t'(s_axis_tdata)));
                ops_sent++;
            end
        end
    end

    // receiver stall pattern, plus one long hold-off
    int rx_phase;
    int hold_count;
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_phase = 0;
            hold_count = 0;
        end
        else
        begin
            rx_phase++;
            if (ops_sent == 300 && hold_count == 0)
                hold_count = 400;
            if (hold_count > 1)
            begin
                hold_count--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_phase % 600 < 200)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 9) < 6);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        res_beat_t got;
        res_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = res_beat_t'(m_axis_tdata[73:0]);
            results_seen++;
            if (result_queue.size() == 0)
                report_mismatch("unexpected beat", 32'd0, 32'd0);
            else
            begin
                want = result_queue.pop_front();
                if (want.raise_exception)
                    exc_seen++;
                if (got.write_enable != want.write_enable)
                    report_mismatch("write_enable", 32'(got.write_enable),
                                    32'(want.write_enable));
                if (got.write_value != want.write_value)
                    report_mismatch("write_value", got.write_value, want.write_value);
                if (got.redirect_kind != want.redirect_kind)
                    report_mismatch("redirect_kind", 32'(got.redirect_kind),
                                    32'(want.redirect_kind));
                if (got.redirect_target != want.redirect_target)
                    report_mismatch("redirect_target", got.redirect_target,
                                    want.redirect_target);
                if (got.raise_exception != want.raise_exception)
                    report_mismatch("raise_exception", 32'(got.raise_exception),
                                    32'(want.raise_exception));
                if (got.exc_code != want.exc_code)
                    report_mismatch("exc_code", 32'(got.exc_code), 32'(want.exc_code));
                if (got.halt != want.halt)
                    report_mismatch("halt", 32'(got.halt), 32'(want.halt));
            end
        end
    end

    // watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // end of run
    initial
    begin
        fork
            begin
                wait (stim_done && !s_axis_tvalid && result_queue.size() == 0);
                repeat (50) @(posedge clk);
                $display("ran %0d ops, checked %0d result beats, %0d exceptions",
                         ops_sent, results_seen, exc_seen);
                if (error_count == 0 && result_queue.size() == 0)
                    $display("CHECK OK");
                else
                    $display("CHECK FAILED");
            end
            begin
                wait (idle_cycles >= IDLE_LIMIT);
                $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
            end
        join_any
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/mrte_pkg.sv
hw/rtl/mrte_divider.sv
hw/rtl/mips_r_type_execute_unit.sv
sim/tb_top.sv
